// ===== sv/sha256_stream_hasher_assert.svh =====
// assertion macros for the sha-256 stream hasher checker
// no dependencies
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SHA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sha256 check failed");

// next-cycle implication, disabled in reset
`define SHA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sha256 check failed");

`endif

// ===== sv/sha_pkg.sv =====
// constants and helpers for the sha-256 stream hasher
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

   localparam int unsigned WordW = 32;
   localparam int unsigned OutTdataW = 40;

   localparam logic [31:0] K_TABLE [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] IV_TABLE [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PAD_BYTE = 8'h80;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      logic [63:0] dbl;
      dbl = {x, x} >> n;
      return dbl[31:0];
   endfunction

   function automatic logic [31:0] sig0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] sig1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] bsig0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] bsig1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

endpackage
`default_nettype wire

// ===== sv/sha256_stream_hasher.sv =====
// message bytes are gathered into 16-word blocks; a full block runs load, 64 rounds, then add
// a finishing beat pushes padding and length one byte per cycle, pausing while a block
// compresses; one or two compressions, then 8 digest beats; the round loop sets the block rate
// throughput: one byte beat per cycle while gathering; req_tready drops during
// every compression, the padding pass and the digest beats
// reset: synchronous, active high; hash returns to the initial vector, counts to zero
`timescale 1ns / 1ps
`default_nettype none
module sha256_stream_hasher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte [7:0]
   input  wire logic        req_tuser,   // has_byte
   input  wire logic        req_tlast,   // end_of_message
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [sha_pkg::OutTdataW-1:0] rsp_tdata, // digest_word [31:0], word_index [34:32]
   output logic             rsp_tlast    // last_word
);
   import sha_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PAD, ST_LEN, ST_LOAD, ST_COMP, ST_ADD, ST_OUT
   } state_type;

   state_type   state_ff, ret_ff;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] count_ff;
   logic [31:0] word_ff, word_in;
   logic        pad80_ff;
   logic [5:0]  rnd_ff;
   logic [2:0]  idx_ff;
   logic [31:0] hash_ff [8];
   logic [31:0] var_ff [8];
   logic [31:0] win_ff [16];

   // message block memory, 16 words, registered read
   logic [31:0] msg_mem [16];
   logic [31:0] msg_rd_ff;
   logic [3:0]  rd_addr;

   logic        req_acc;
   logic        push_vld;
   logic [7:0]  push_dat;
   logic [63:0] len_sh;
   logic [31:0] w_new, w_use, t1, t2;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;

   // byte source: input beat, padding, or big-endian bit length
   assign len_sh = {count_ff[60:0], 3'b000} >> {~fill_ff[2:0], 3'b000};

   always_comb begin
      push_vld = 1'b0;
      push_dat = '0;
      unique case (state_ff)
         ST_IDLE: begin
            push_vld = req_acc && req_tuser;
            push_dat = req_tdata;
         end
         ST_PAD: begin
            push_vld = 1'b1;
            push_dat = pad80_ff ? PAD_BYTE : 8'h00;
         end
         ST_LEN: begin
            push_vld = 1'b1;
            push_dat = len_sh[7:0];
         end
         default: begin
            push_vld = 1'b0;
            push_dat = '0;
         end
      endcase
   end

   assign word_in = {word_ff[23:0], push_dat};
   assign fill_in = fill_ff + 6'd1;
   assign rd_addr = (state_ff == ST_COMP) ? (rnd_ff[3:0] + 4'd1) : 4'd0;

   always_ff @(posedge clock) begin
      if (push_vld && (fill_ff[1:0] == 2'd3)) begin
         msg_mem[fill_ff[5:2]] <= word_in;
      end
      msg_rd_ff <= msg_mem[rd_addr];
   end

   // one round of the compression, window taps fixed
   assign w_new = sig1(win_ff[14]) + win_ff[9] + sig0(win_ff[1]) + win_ff[0];
   assign w_use = (rnd_ff < 6'd16) ? msg_rd_ff : w_new;
   assign t1 = var_ff[7] + bsig1(var_ff[4])
             + ((var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]))
             + K_TABLE[rnd_ff] + w_use;
   assign t2 = bsig0(var_ff[0])
             + ((var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         fill_ff  <= '0;
         count_ff <= '0;
         pad80_ff <= 1'b0;
         rnd_ff   <= '0;
         idx_ff   <= '0;
         for (int i = 0; i < 8; i++) hash_ff[i] <= IV_TABLE[i];
      end else begin
         if (push_vld) begin
            word_ff <= word_in;
            fill_ff <= fill_in;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  if (req_tuser) count_ff <= count_ff + 64'd1;
                  if (req_tlast) pad80_ff <= 1'b1;
                  if (req_tuser && (fill_ff == 6'd63)) begin
                     state_ff <= ST_LOAD;
                     ret_ff   <= req_tlast ? ST_PAD : ST_IDLE;
                  end else if (req_tlast) begin
                     state_ff <= ST_PAD;
                  end
               end
            end
            ST_PAD: begin
               pad80_ff <= 1'b0;
               if (fill_ff == 6'd63) begin
                  state_ff <= ST_LOAD;
                  ret_ff   <= ST_PAD;
               end else if (fill_ff == 6'd55) begin
                  state_ff <= ST_LEN;
               end
            end
            ST_LEN: begin
               if (fill_ff == 6'd63) begin
                  state_ff <= ST_LOAD;
                  ret_ff   <= ST_OUT;
               end
            end
            ST_LOAD: begin
               for (int i = 0; i < 8; i++) var_ff[i] <= hash_ff[i];
               rnd_ff   <= '0;
               state_ff <= ST_COMP;
            end
            ST_COMP: begin
               for (int i = 0; i < 15; i++) win_ff[i] <= win_ff[i+1];
               win_ff[15] <= w_use;
               var_ff[7] <= var_ff[6];
               var_ff[6] <= var_ff[5];
               var_ff[5] <= var_ff[4];
               var_ff[4] <= var_ff[3] + t1;
               var_ff[3] <= var_ff[2];
               var_ff[2] <= var_ff[1];
               var_ff[1] <= var_ff[0];
               var_ff[0] <= t1 + t2;
               rnd_ff <= rnd_ff + 6'd1;
               if (rnd_ff == 6'd63) state_ff <= ST_ADD;
            end
            ST_ADD: begin
               for (int i = 0; i < 8; i++) hash_ff[i] <= hash_ff[i] + var_ff[i];
               idx_ff   <= '0;
               state_ff <= ret_ff;
            end
            ST_OUT: begin
               if (rsp_tready) begin
                  idx_ff <= idx_ff + 3'd1;
                  if (idx_ff == 3'd7) begin
                     for (int i = 0; i < 8; i++) hash_ff[i] <= IV_TABLE[i];
                     count_ff <= '0;
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {5'b00000, idx_ff, hash_ff[idx_ff]};
   assign rsp_tlast  = (idx_ff == 3'd7);

endmodule
`default_nettype wire

// ===== sv/sha256_stream_hasher_checker.sv =====
// port-level checker for the sha-256 stream hasher, bound to the top level
// depends on sha_pkg and sha256_stream_hasher_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "sha256_stream_hasher_assert.svh"
module sha256_stream_hasher_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tready,
   input wire logic rsp_tvalid,
   input wire logic rsp_tready,
   input wire logic [sha_pkg::OutTdataW-1:0] rsp_tdata,
   input wire logic rsp_tlast
);
   import sha_pkg::*;

   // input side is closed while a digest is out
   `SHA_ASSERT_NOW(a_no_overlap, clock, reset, rsp_tvalid, !req_tready)
   // last marker only on word seven
   `SHA_ASSERT_NOW(a_last_idx, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata[34:32] == 3'd7)
   // digest ends after its last beat
   `SHA_ASSERT_NEXT(a_end, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast, !rsp_tvalid)
   // stalled beat holds
   `SHA_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule

bind sha256_stream_hasher sha256_stream_hasher_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
